@@ hw/rtl/tfn_pkg.sv @@
package tfn_pkg;

    // Default field widths of the vertex and normal channels.
    localparam int COORD_WIDTH_DEF  = 24;
    localparam int NORMAL_WIDTH_DEF = 16;

    // Width of the components-per-vertex register.
    localparam int CFG_W = 5;

endpackage

@@ hw/rtl/tfn_in_if.sv @@
interface tfn_in_if #(
    parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] component_value;
    logic                          mesh_start;

    modport source (
        output valid,
        output component_value,
        output mesh_start,
        input  ready
    );

    modport sink (
        input  valid,
        input  component_value,
        input  mesh_start,
        output ready
    );
endinterface

@@ hw/rtl/tfn_out_if.sv @@
interface tfn_out_if #(
    parameter int NORMAL_WIDTH = tfn_pkg::NORMAL_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [NORMAL_WIDTH-1:0] normal_x;
    logic signed [NORMAL_WIDTH-1:0] normal_y;
    logic signed [NORMAL_WIDTH-1:0] normal_z;
    logic                           degenerate;
    logic                           last;

    modport source (
        output valid,
        output normal_x,
        output normal_y,
        output normal_z,
        output degenerate,
        output last,
        input  ready
    );

    modport sink (
        input  valid,
        input  normal_x,
        input  normal_y,
        input  normal_z,
        input  degenerate,
        input  last,
        output ready
    );
endinterface

@@ hw/rtl/triangle_face_normal_top.sv @@
// Face normal unit. Vertex components arrive one per transaction in signed Q8.16; each
// vertex spans components_per_vertex transactions (3 to 16, only x, y, z are kept) and
// every third vertex closes a triangle. Components that do not close a triangle are taken
// in the cycle they are offered while the unit is idle. The closing component starts the
// normal computation, during which the input is not ready: the edges, the cross product on
// the shared 32x32 multiplier, the magnitudes, the scaling, the sum of squares, the
// bit-per-cycle square root and, for each axis, the restoring divider that produces one
// quotient bit per cycle. The unit normal, in signed Q1.(NORMAL_WIDTH-2) rounded to
// nearest, then goes out three times, once per vertex, with last set on the third copy; a
// zero cross product gives zeros with degenerate set. While those three results are
// offered, further components are accepted unless the counters stand at the next
// triangle's closing one. A mesh_start component restarts vertex and triangle counting.
module triangle_face_normal_top #(
    parameter int COORD_WIDTH  = tfn_pkg::COORD_WIDTH_DEF,
    parameter int NORMAL_WIDTH = tfn_pkg::NORMAL_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tfn_pkg::CFG_W-1:0] i_cfg_wdata,
    tfn_in_if.sink                    i_in,
    tfn_out_if.source                 o_out
);
    import tfn_pkg::*;

    localparam int AXES       = 3;
    localparam int HELD_DEPTH = 9;
    localparam int CPV_MIN    = 3;
    localparam int CPV_MAX    = 16;
    localparam int EDGE_W     = 32;
    localparam int ACC_W      = 64;
    localparam int A_W        = 30;
    localparam int COARSE     = 8;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = 32;
    localparam int FRAC       = NORMAL_WIDTH - 2;
    localparam int QB         = FRAC + 1;
    localparam int NUM_W      = A_W + QB + 1;
    localparam int CNT_W      = $clog2(SQRT_STEPS > QB ? SQRT_STEPS : QB);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_CROSS,
        S_MAG,
        S_NORM,
        S_SQ,
        S_SQRT,
        S_DIVI,
        S_DIV,
        S_EMIT
    } t_state;

    // Fits a 33-bit edge into 32 bits: when any magnitude in an edge reaches 2^31 the caller
    // halves all of that edge's components, truncating the magnitude and keeping the sign.
    function automatic logic signed [EDGE_W-1:0] halve_edge(
        input logic signed [EDGE_W:0] d
    );
        logic [EDGE_W:0] sum;
        sum = d + {{EDGE_W{1'b0}}, d[EDGE_W]};
        return sum[EDGE_W:1];
    endfunction

    function automatic logic edge_big(input logic signed [EDGE_W:0] d);
        return (d[EDGE_W] ^ d[EDGE_W-1]) ||
               (d[EDGE_W] && d[EDGE_W-1] && (d[EDGE_W-2:0] == '0));
    endfunction

    t_state                          r_state;
    logic [CFG_W-1:0]                r_cpv;
    logic [3:0]                      r_cpos;
    logic [1:0]                      r_vpos;
    logic signed [COORD_WIDTH-1:0]   r_held [HELD_DEPTH];
    logic signed [EDGE_W-1:0]        r_e1 [AXES];
    logic signed [EDGE_W-1:0]        r_e2 [AXES];
    logic signed [ACC_W-1:0]         r_prod;
    logic signed [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]                r_c [AXES];
    logic                            r_neg [AXES];
    logic                            r_degen;
    logic [ACC_W-1:0]                r_s;
    logic [ACC_W-1:0]                r_res;
    logic [ACC_W-1:0]                r_bit;
    logic [ROOT_W-1:0]               r_rem;
    logic [ROOT_W-1:0]               r_div;
    logic [QB-1:0]                   r_low;
    logic [QB-1:0]                   r_q;
    logic [1:0]                      r_axis;
    logic signed [NORMAL_WIDTH-1:0]  r_norm [AXES];
    logic [CNT_W-1:0]                r_cnt;
    logic [1:0]                      r_emit;
    logic                            r_out_valid;

    logic                            in_ready;
    logic                            in_fire;
    logic                            out_fire;
    logic [CFG_W-1:0]                eff_cpv;
    logic [3:0]                      last_comp;
    logic [3:0]                      cur_cpos;
    logic [1:0]                      cur_vpos;
    logic [3:0]                      wr_idx;
    logic                            wr_en;
    logic                            comp_end;
    logic                            tri_done;
    logic [3:0]                      n_cpos;
    logic [1:0]                      n_vpos;
    logic signed [EDGE_W:0]          d1 [AXES];
    logic signed [EDGE_W:0]          d2 [AXES];
    logic                            big1;
    logic                            big2;
    logic signed [EDGE_W-1:0]        n_e1 [AXES];
    logic signed [EDGE_W-1:0]        n_e2 [AXES];
    logic signed [EDGE_W-1:0]        mul_a;
    logic signed [EDGE_W-1:0]        mul_b;
    logic signed [ACC_W-1:0]         mul_p;
    logic [A_W-1:0]                  sq_sel;
    logic [CNT_W-1:0]                cross_k;
    logic                            hi_coarse;
    logic                            hi_fine;
    logic                            lo_coarse;
    logic                            lo_fine;
    logic [ACC_W-1:0]                sq_t;
    logic [NUM_W-1:0]                num;
    logic [ROOT_W:0]                 div_sh;
    logic                            div_ge;
    logic [ROOT_W:0]                 div_diff;
    logic [QB-1:0]                   q_full;
    logic [QB-1:0]                   q_clamp;
    logic signed [NORMAL_WIDTH-1:0]  q_signed;

    // Input side: counters and the store of held coordinates.
    always_comb begin
        if (r_cpv < CFG_W'(CPV_MIN)) begin
            eff_cpv = CFG_W'(CPV_MIN);
        end else if (r_cpv > CFG_W'(CPV_MAX)) begin
            eff_cpv = CFG_W'(CPV_MAX);
        end else begin
            eff_cpv = r_cpv;
        end
        last_comp = 4'(eff_cpv - 1'b1);
        cur_cpos  = i_in.mesh_start ? 4'd0 : r_cpos;
        cur_vpos  = (i_in.mesh_start || r_vpos > 2'd2) ? 2'd0 : r_vpos;
        wr_idx    = {1'b0, cur_vpos, 1'b0} + {2'b00, cur_vpos} + cur_cpos;
        wr_en     = cur_cpos < 4'(AXES);
        comp_end  = cur_cpos >= last_comp;
        tri_done  = comp_end && (cur_vpos == 2'd2);
        n_cpos    = comp_end ? 4'd0 : cur_cpos + 4'd1;
        if (!comp_end) begin
            n_vpos = cur_vpos;
        end else if (cur_vpos < 2'd2) begin
            n_vpos = cur_vpos + 2'd1;
        end else begin
            n_vpos = 2'd0;
        end
    end

    // While results are offered, only components that cannot close a triangle are taken.
    assign in_ready = (r_state == S_IDLE) ||
                      ((r_state == S_EMIT) && !((r_vpos == 2'd2) && (r_cpos >= last_comp)));
    assign in_fire  = i_in.valid && in_ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign i_in.ready = in_ready;

    // Edges at full width, halved when any magnitude does not fit 31 bits.
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            d1[i] = (EDGE_W+1)'(r_held[AXES+i]) - (EDGE_W+1)'(r_held[i]);
            d2[i] = (EDGE_W+1)'(r_held[2*AXES+i]) - (EDGE_W+1)'(r_held[i]);
        end
        big1 = edge_big(d1[0]) || edge_big(d1[1]) || edge_big(d1[2]);
        big2 = edge_big(d2[0]) || edge_big(d2[1]) || edge_big(d2[2]);
        for (int i = 0; i < AXES; i++) begin
            n_e1[i] = big1 ? halve_edge(d1[i]) : d1[i][EDGE_W-1:0];
            n_e2[i] = big2 ? halve_edge(d2[i]) : d2[i][EDGE_W-1:0];
        end
    end

    // Shared multiplier: cross product terms, then the squares of the scaled components.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_sel = r_c[0][A_W-1:0];
            2'd1:    sq_sel = r_c[1][A_W-1:0];
            default: sq_sel = r_c[2][A_W-1:0];
        endcase
        case (r_state)
            S_CROSS: begin
                case (r_cnt[2:0])
                    3'd0: begin
                        mul_a = r_e1[1];
                        mul_b = r_e2[2];
                    end
                    3'd1: begin
                        mul_a = r_e1[2];
                        mul_b = r_e2[1];
                    end
                    3'd2: begin
                        mul_a = r_e1[2];
                        mul_b = r_e2[0];
                    end
                    3'd3: begin
                        mul_a = r_e1[0];
                        mul_b = r_e2[2];
                    end
                    3'd4: begin
                        mul_a = r_e1[0];
                        mul_b = r_e2[1];
                    end
                    default: begin
                        mul_a = r_e1[1];
                        mul_b = r_e2[0];
                    end
                endcase
            end
            S_SQ: begin
                mul_a = {{(EDGE_W-A_W){1'b0}}, sq_sel};
                mul_b = {{(EDGE_W-A_W){1'b0}}, sq_sel};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p   = mul_a * mul_b;
        cross_k = r_cnt - 1'b1;
    end

    // Scaling flags: the largest magnitude is compared against powers of two by
    // checking the upper bits of all three components.
    always_comb begin
        hi_coarse = 1'b0;
        hi_fine   = 1'b0;
        lo_coarse = 1'b1;
        lo_fine   = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            hi_coarse = hi_coarse || (r_c[i][ACC_W-1:A_W+COARSE] != '0);
            hi_fine   = hi_fine   || (r_c[i][ACC_W-1:A_W] != '0);
            lo_coarse = lo_coarse && (r_c[i][ACC_W-1:A_W-1-COARSE] == '0);
            lo_fine   = lo_fine   && (r_c[i][ACC_W-1:A_W-1] == '0);
        end
    end

    // Square root step, divider setup and divider step.
    always_comb begin
        sq_t     = r_res + r_bit;
        num      = {1'b0, r_c[r_axis][A_W-1:0], {QB{1'b0}}};
        num      = num + {{(NUM_W-ROOT_W+1){1'b0}}, r_res[ROOT_W-2:0]};
        div_sh   = {r_rem, r_low[QB-1]};
        div_ge   = div_sh >= {1'b0, r_div};
        div_diff = div_sh - {1'b0, r_div};
        q_full   = {r_q[QB-2:0], div_ge};
        q_clamp  = (q_full > QB'(1) << FRAC) ? QB'(1) << FRAC : q_full;
        q_signed = r_neg[r_axis] ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cpv       <= CFG_W'(CPV_MIN);
            r_cpos      <= '0;
            r_vpos      <= '0;
            r_cnt       <= '0;
            r_axis      <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cpv <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_cpos <= n_cpos;
                r_vpos <= n_vpos;
                for (int j = 0; j < HELD_DEPTH; j++) begin
                    if (wr_en && wr_idx == 4'(j)) begin
                        r_held[j] <= i_in.component_value;
                    end
                end
            end
            r_prod <= mul_p;

            case (r_state)
                S_IDLE: begin
                    if (in_fire && tri_done) begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    r_e1    <= n_e1;
                    r_e2    <= n_e2;
                    r_cnt   <= '0;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    // The product issued in the previous cycle is combined here.
                    if (r_cnt != '0) begin
                        if (!cross_k[0]) begin
                            r_acc <= r_prod;
                        end else begin
                            r_c[cross_k[2:1]] <= r_acc - r_prod;
                        end
                    end
                    if (r_cnt == CNT_W'(2 * AXES)) begin
                        r_state <= S_MAG;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_MAG: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_neg[i]  <= r_c[i][ACC_W-1];
                        r_c[i]    <= r_c[i][ACC_W-1] ? ACC_W'(0) - r_c[i] : r_c[i];
                        r_norm[i] <= '0;
                    end
                    r_degen <= (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
                    if ((r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0)) begin
                        r_emit      <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (hi_coarse) begin
                        for (int i = 0; i < AXES; i++) r_c[i] <= r_c[i] >> COARSE;
                    end else if (hi_fine) begin
                        for (int i = 0; i < AXES; i++) r_c[i] <= r_c[i] >> 1;
                    end else if (lo_coarse) begin
                        for (int i = 0; i < AXES; i++) r_c[i] <= r_c[i] << COARSE;
                    end else if (lo_fine) begin
                        for (int i = 0; i < AXES; i++) r_c[i] <= r_c[i] << 1;
                    end else begin
                        r_cnt   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt == CNT_W'(1)) begin
                        r_s <= r_prod;
                    end else if (r_cnt != '0) begin
                        r_s <= r_s + r_prod;
                    end
                    if (r_cnt == CNT_W'(AXES)) begin
                        r_res   <= '0;
                        r_bit   <= ACC_W'(1) << (ACC_W - 2);
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_s >= sq_t) begin
                        r_s   <= r_s - sq_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_axis  <= '0;
                        r_state <= S_DIVI;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_DIVI: begin
                    // Numerator is |a| * 2^(FRAC+1) + R over a divisor of 2R; its upper
                    // part is already below the divisor since |a| never exceeds R.
                    r_rem   <= ROOT_W'(num[NUM_W-1:QB]);
                    r_low   <= num[QB-1:0];
                    r_div   <= {r_res[ROOT_W-2:0], 1'b0};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_ge) begin
                        r_rem <= div_diff[ROOT_W-1:0];
                    end else begin
                        r_rem <= div_sh[ROOT_W-1:0];
                    end
                    r_q   <= q_full;
                    r_low <= r_low << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(QB - 1)) begin
                        r_norm[r_axis] <= q_signed;
                        if (r_axis == 2'd2) begin
                            r_emit      <= '0;
                            r_out_valid <= 1'b1;
                            r_state     <= S_EMIT;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_DIVI;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_fire) begin
                        if (r_emit == 2'd2) begin
                            r_out_valid <= 1'b0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_emit <= r_emit + 2'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.normal_x   = r_norm[0];
    assign o_out.normal_y   = r_norm[1];
    assign o_out.normal_z   = r_norm[2];
    assign o_out.degenerate = r_degen;
    assign o_out.last       = r_emit == 2'd2;

endmodule

@@ sim/triangle_face_normal_top_test.sv @@
`timescale 1ns / 1ps

module triangle_face_normal_top_test;

    localparam int CW = tfn_pkg::COORD_WIDTH_DEF;
    localparam int NW = tfn_pkg::NORMAL_WIDTH_DEF;
    localparam int FRAC = NW - 2;
    localparam int SETTLE_CYCLES = 160;

    typedef struct {
        logic signed [CW-1:0] value;
        logic                 mesh_start;
    } component_t;

    typedef struct {
        logic signed [NW-1:0] normal_x;
        logic signed [NW-1:0] normal_y;
        logic signed [NW-1:0] normal_z;
        logic                 degenerate;
        logic                 last;
    } normal_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [tfn_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic send_valid = 1'b0;
    logic signed [CW-1:0] send_value = '0;
    logic send_start = 1'b0;
    logic take_ready = 1'b0;

    tfn_in_if  #(.COORD_WIDTH(CW))  in_if ();
    tfn_out_if #(.NORMAL_WIDTH(NW)) out_if ();

    assign in_if.valid = send_valid;
    assign in_if.component_value = send_value;
    assign in_if.mesh_start = send_start;
    assign out_if.ready = take_ready;

    triangle_face_normal_top #(
        .COORD_WIDTH(CW),
        .NORMAL_WIDTH(NW)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in(in_if.sink),
        .o_out(out_if.source)
    );

    component_t pending_components[$];
    normal_t normals_due[$];
    bit calm = 1'b0;
    int send_gap = 0;
    int take_stall = 0;
    int errors = 0;
    int components_sent = 0;
    int normals_checked = 0;
    int degenerate_seen = 0;
    int triangles_seen = 0;

    // Mirror of the block's counters, vertex store and span register.
    logic [tfn_pkg::CFG_W-1:0] span_reg = 5'd3;
    int comp_idx = 0;
    int vert_idx = 0;
    logic signed [CW-1:0] corner_coord [9];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int effective_span(input logic [tfn_pkg::CFG_W-1:0] code);
        if (code < 3) return 3;
        if (code > 16) return 16;
        return int'(code);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned s);
        longint unsigned res;
        longint unsigned probe;
        longint unsigned rem;
        res = 0;
        rem = s;
        probe = 64'd1 << 62;
        while (probe > rem) probe >>= 2;
        while (probe != 0) begin
            if (rem >= res + probe) begin
                rem -= res + probe;
                res = (res >> 1) + probe;
            end else begin
                res >>= 1;
            end
            probe >>= 2;
        end
        return res;
    endfunction

    // Cross product of the edges from vertex 0 to the other vertices, with its largest
    // magnitude brought to [2^29, 2^30), divided by its rounded-down length.
    function automatic normal_t face_unit_normal();
        longint signed e1 [3];
        longint signed e2 [3];
        longint signed c [3];
        longint unsigned a [3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned r;
        longint unsigned v;
        logic signed [NW-1:0] q [3];
        normal_t n;
        for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(corner_coord[3 + i]) - longint'(corner_coord[i]);
            e2[i] = longint'(corner_coord[6 + i]) - longint'(corner_coord[i]);
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
            if (a[i] > m) m = a[i];
            q[i] = '0;
        end
        n.degenerate = (m == 0);
        n.last = 1'b0;
        if (m != 0) begin
            while (m >= (64'd1 << 30)) begin
                m >>= 1;
                for (int i = 0; i < 3; i++) a[i] >>= 1;
            end
            while (m < (64'd1 << 29)) begin
                m <<= 1;
                for (int i = 0; i < 3; i++) a[i] <<= 1;
            end
            s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            r = floor_sqrt(s);
            for (int i = 0; i < 3; i++) begin
                v = ((a[i] << (FRAC + 1)) + r) / (2 * r);
                if (v > (64'd1 << FRAC)) v = 64'd1 << FRAC;
                q[i] = (c[i] < 0) ? NW'(-longint'(v)) : NW'(v);
            end
        end
        n.normal_x = q[0];
        n.normal_y = q[1];
        n.normal_z = q[2];
        return n;
    endfunction

    task automatic take_component(input logic signed [CW-1:0] value, input logic start);
        int span;
        normal_t n;
        span = effective_span(span_reg);
        if (start) begin
            comp_idx = 0;
            vert_idx = 0;
        end
        if (comp_idx < 3) corner_coord[vert_idx * 3 + comp_idx] = value;
        // A span shortened mid-vertex ends the vertex on the current component.
        if (comp_idx < span - 1) begin
            comp_idx++;
            return;
        end
        comp_idx = 0;
        if (vert_idx < 2) begin
            vert_idx++;
            return;
        end
        vert_idx = 0;
        n = face_unit_normal();
        for (int k = 0; k < 3; k++) begin
            n.last = (k == 2);
            normals_due = {normals_due, n};
        end
    endtask

    task automatic report_field(input string field, input longint want, input longint got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
    endtask

    // Sender: offers the next queued transaction once the previous one has been taken, with random gaps unless calm.
    always @(posedge i_clk) begin
        component_t c;
        if (!i_rst_n) begin
            send_valid <= 1'b0;
        end else if (!send_valid || in_if.ready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                send_valid <= 1'b0;
            end else if (pending_components.size() != 0 && !calm
                         && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 2);
                send_valid <= 1'b0;
            end else if (pending_components.size() != 0) begin
                c = pending_components.pop_front();
                send_valid <= 1'b1;
                send_value <= c.value;
                send_start <= c.mesh_start;
            end else begin
                send_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            take_ready <= 1'b0;
        end else if (take_stall > 0) begin
            take_stall <= take_stall - 1;
            take_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            take_stall <= $urandom_range(0, 2);
            take_ready <= 1'b0;
        end else begin
            take_ready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted component, checks every accepted normal.
    always @(posedge i_clk) begin
        normal_t got;
        normal_t want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                components_sent++;
                take_component(in_if.component_value, in_if.mesh_start);
            end
            if (out_if.valid && out_if.ready) begin
                got.normal_x = out_if.normal_x;
                got.normal_y = out_if.normal_y;
                got.normal_z = out_if.normal_z;
                got.degenerate = out_if.degenerate;
                got.last = out_if.last;
                if (normals_due.size() == 0) begin
                    $display("%0t ns: unexpected normal, expected none, actual %0d %0d %0d d=%0b l=%0b",
                             $time, got.normal_x, got.normal_y, got.normal_z,
                             got.degenerate, got.last);
                    errors++;
                end else begin
                    want = normals_due.pop_front();
                    normals_checked++;
                    if (want.degenerate) degenerate_seen++;
                    if (want.last) triangles_seen++;
                    if (got.normal_x !== want.normal_x)
                        report_field("normal_x", want.normal_x, got.normal_x);
                    if (got.normal_y !== want.normal_y)
                        report_field("normal_y", want.normal_y, got.normal_y);
                    if (got.normal_z !== want.normal_z)
                        report_field("normal_z", want.normal_z, got.normal_z);
                    if (got.degenerate !== want.degenerate)
                        report_field("degenerate", want.degenerate, got.degenerate);
                    if (got.last !== want.last)
                        report_field("last", want.last, got.last);
                end
            end
        end
    end

    task automatic push_component(input logic signed [CW-1:0] value, input logic start);
        component_t c;
        c.value = value;
        c.mesh_start = start;
        pending_components = {pending_components, c};
    endtask

    task automatic push_vertex(input int x, input int y, input int z, input logic start);
        push_component(CW'(x), start);
        push_component(CW'(y), 1'b0);
        push_component(CW'(z), 1'b0);
    endtask

    // One well-formed triangle with random content; extra components are random.
    task automatic queue_triangle(input int span, input logic start);
        logic signed [CW-1:0] xyz [9];
        int kind;
        int dx;
        int dy;
        int dz;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            if (kind <= 4) begin
                xyz[i] = CW'($urandom);
            end else if (kind <= 6) begin
                xyz[i] = CW'(int'($urandom_range(0, 600)) - 300);
            end else begin
                case ($urandom_range(0, 3))
                    0: xyz[i] = {1'b1, {(CW-1){1'b0}}};
                    1: xyz[i] = {1'b0, {(CW-1){1'b1}}};
                    2: xyz[i] = '0;
                    default: xyz[i] = '1;
                endcase
            end
        end
        if (kind >= 8) begin
            // Collinear or repeated vertices give a zero cross product.
            dx = int'($urandom_range(0, 2000)) - 1000;
            dy = int'($urandom_range(0, 2000)) - 1000;
            dz = int'($urandom_range(0, 2000)) - 1000;
            for (int i = 0; i < 3; i++) xyz[i] = CW'(int'($urandom_range(0, 200000)) - 100000);
            if (kind == 8) begin
                for (int i = 0; i < 3; i++) xyz[6 + i] = xyz[i];
            end else begin
                xyz[3] = xyz[0] + CW'(dx);
                xyz[4] = xyz[1] + CW'(dy);
                xyz[5] = xyz[2] + CW'(dz);
                xyz[6] = xyz[0] + CW'(2 * dx);
                xyz[7] = xyz[1] + CW'(2 * dy);
                xyz[8] = xyz[2] + CW'(2 * dz);
            end
        end
        for (int v = 0; v < 3; v++) begin
            for (int k = 0; k < span; k++) begin
                if (k < 3) push_component(xyz[v * 3 + k], start && v == 0 && k == 0);
                else push_component(CW'($urandom), 1'b0);
            end
        end
    endtask

    task automatic queue_phase(input int budget, input int span);
        int queued;
        int n;
        bit resync;
        queued = 0;
        resync = 1'b1;
        while (queued < budget) begin
            if ($urandom_range(0, 7) == 0) begin
                // Broken sequence: partial vertices with stray restarts.
                n = $urandom_range(1, 3 * span - 1);
                for (int i = 0; i < n; i++)
                    push_component(CW'($urandom), $urandom_range(0, 3) == 0);
                queued += n;
                resync = ($urandom_range(0, 3) != 0);
            end else begin
                queue_triangle(span, resync || $urandom_range(0, 2) == 0);
                queued += 3 * span;
                resync = 1'b0;
            end
        end
    endtask

    task automatic wait_quiet();
        while (pending_components.size() != 0 || send_valid || normals_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_span(input logic [tfn_pkg::CFG_W-1:0] code);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= code;
        span_reg = code;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [tfn_pkg::CFG_W-1:0] codes [6];
        int budgets [6];
        codes = '{5'd16, 5'd0, 5'd5, 5'd31, 5'($urandom_range(6, 15)), 5'd3};
        budgets = '{40, 60, 50, 40, 40, 60};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-scale corners, a restart mid-triangle, a flat triangle.
        push_vertex(-8388608, -8388608, -8388608, 1'b1);
        push_vertex(8388607, -8388608, -8388608, 1'b0);
        push_vertex(-8388608, 8388607, -8388608, 1'b0);
        push_component(CW'(1), 1'b0);
        push_component(CW'(-1), 1'b0);
        push_component(24'h555555, 1'b0);
        push_component(24'hAAAAAA, 1'b0);
        push_vertex(0, 0, 0, 1'b1);
        push_vertex(1, 1, 1, 1'b0);
        push_vertex(2, 2, 2, 1'b0);
        wait_quiet();

        for (int p = 0; p < 6; p++) begin
            write_span(codes[p]);
            if (p == 5) calm = 1'b1;
            queue_phase(budgets[p], effective_span(codes[p]));
            wait_quiet();
        end

        $display("Sent %0d components; checked %0d normals from %0d triangles, %0d degenerate.",
                 components_sent, normals_checked, triangles_seen, degenerate_seen);
        $display("Span codes 0, 3, 5, 16, 31 and one random setting, with restarts and stalls.");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("Timed out with %0d components pending and %0d normals due.",
                 pending_components.size(), normals_due.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_in_if.sv
hw/rtl/tfn_out_if.sv
hw/rtl/triangle_face_normal_top.sv
sim/triangle_face_normal_top_test.sv
